// ----- rtl/lca_pkg.sv -----
// Shared types, codes and the generation rule for the life grid core.
`default_nettype none
package lca_pkg;

  localparam int INDEX_W = 4;
  localparam int COUNT_W = 4;
  localparam int NBR_N   = 8;

  localparam logic [COUNT_W-1:0] LIVE_MIN    = 4'd2;
  localparam logic [COUNT_W-1:0] LIVE_MAX    = 4'd3;
  localparam logic [COUNT_W-1:0] BIRTH_COUNT = 4'd3;

  typedef enum logic [1:0] {
    ACT_WRITE = 2'd0,
    ACT_STEP  = 2'd1,
    ACT_READ  = 2'd2
  } action_t;

  // Per-cell control for one cycle
  typedef struct packed {
    logic step;
    logic wr;
    logic wr_value;
  } cell_ctrl_t;

  // Generation rule: survive on two or three, birth on three
  function automatic logic next_state(input logic alive, input logic [COUNT_W-1:0] count);
    logic result;
    if (alive) begin
      result = (count >= LIVE_MIN) && (count <= LIVE_MAX);
    end else begin
      result = (count == BIRTH_COUNT);
    end
    return result;
  endfunction

endpackage
`default_nettype wire

// ----- rtl/lca_cell.sv -----
// One grid cell: holds its state, counts its live neighbors, evolves on step if EVOLVE is set.
`default_nettype none
module lca_cell
  import lca_pkg::*;
#(
  parameter bit EVOLVE = 1'b1
) (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire cell_ctrl_t         ctrl,
  input  wire logic [NBR_N-1:0]   nbr,
  output logic                    alive,
  output logic [COUNT_W-1:0]      count
);

  // Count live neighbors from the current grid
  assign count = COUNT_W'($countones(nbr));

  // Hold, load on write, or advance one generation
  always_ff @(posedge clk) begin
    if (rst) begin
      alive <= 1'b0;
    end else if (ctrl.wr) begin
      alive <= ctrl.wr_value;
    end else if (ctrl.step && EVOLVE) begin
      alive <= next_state(alive, count);
    end
  end

endmodule
`default_nettype wire

// ----- rtl/life_cellular_automaton_grid_core.sv -----
// Top level of the life grid core: cell array, item decode and result register.
// The result of an item is registered and strobed on done in the cycle after its transfer.
// Throughput: one item per cycle once busy is low; a step updates every interior cell together
// because each cell evolves itself from its neighbors' registered states.
// Reset clears every cell at once; busy is set in reset and cleared by the first clock after it.
// The receiver cannot stall: every result shows for exactly one cycle.
`default_nettype none
module life_cellular_automaton_grid_core
  import lca_pkg::*;
#(
  parameter int GRID_ROWS = 16,
  parameter int GRID_COLS = 16
) (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               start,
  output logic                    busy,
  input  wire logic [1:0]         action,
  input  wire logic [INDEX_W-1:0] row_index,
  input  wire logic [INDEX_W-1:0] col_index,
  input  wire logic               cell_value,
  output logic                    done,
  output logic                    cell_alive,
  output logic [COUNT_W-1:0]      neighbor_count
);

  logic                   accept;
  logic                   in_grid;
  logic                   do_write;
  logic                   do_step;
  logic                   do_read;
  logic [GRID_ROWS-1:0]   row_hit;
  logic [GRID_COLS-1:0]   col_hit;
  logic                   grid  [GRID_ROWS][GRID_COLS];
  logic [COUNT_W-1:0]     cnt   [GRID_ROWS][GRID_COLS];
  logic                   sel_alive;
  logic [COUNT_W-1:0]     sel_count;
  logic                   cell_alive_next;
  logic [COUNT_W-1:0]     neighbor_count_next;

  assign accept  = start && !busy;
  assign in_grid = (int'(row_index) < GRID_ROWS) && (int'(col_index) < GRID_COLS);

  // Decode the action of the transfer
  always_comb begin
    do_write = 1'b0;
    do_step  = 1'b0;
    do_read  = 1'b0;
    unique case (action)
      ACT_WRITE: do_write = accept && in_grid;
      ACT_STEP:  do_step  = accept;
      ACT_READ:  do_read  = accept && in_grid;
      default:   ;
    endcase
  end

  // Row and column address match
  always_comb begin
    for (int r = 0; r < GRID_ROWS; r++) begin
      row_hit[r] = (int'(row_index) == r);
    end
    for (int c = 0; c < GRID_COLS; c++) begin
      col_hit[c] = (int'(col_index) == c);
    end
  end

  // Build the cell array and its neighbor wiring
  for (genvar r = 0; r < GRID_ROWS; r++) begin : g_row
    for (genvar c = 0; c < GRID_COLS; c++) begin : g_col
      localparam bit INTERIOR = (r >= 1) && (r + 1 < GRID_ROWS) &&
                                (c >= 1) && (c + 1 < GRID_COLS);
      logic [NBR_N-1:0] win;
      cell_ctrl_t ctrl;

      // Pack the eight surrounding cells, skipping the cell itself
      for (genvar dr = 0; dr < 3; dr++) begin : g_dr
        for (genvar dc = 0; dc < 3; dc++) begin : g_dc
          localparam int NBR_IDX = (dr * 3 + dc > 4) ? dr * 3 + dc - 1 : dr * 3 + dc;
          if (!((dr == 1) && (dc == 1))) begin : g_nbr
            if ((r + dr - 1 >= 0) && (r + dr - 1 < GRID_ROWS) &&
                (c + dc - 1 >= 0) && (c + dc - 1 < GRID_COLS)) begin : g_in
              assign win[NBR_IDX] = grid[r+dr-1][c+dc-1];
            end else begin : g_out
              assign win[NBR_IDX] = 1'b0;
            end
          end
        end
      end

      assign ctrl.step     = do_step;
      assign ctrl.wr       = do_write && row_hit[r] && col_hit[c];
      assign ctrl.wr_value = cell_value;

      lca_cell #(
        .EVOLVE (INTERIOR)
      ) u_cell (
        .clk   (clk),
        .rst   (rst),
        .ctrl  (ctrl),
        .nbr   (win),
        .alive (grid[r][c]),
        .count (cnt[r][c])
      );
    end
  end

  // Select the addressed cell; counts come from interior cells only
  always_comb begin
    sel_alive = 1'b0;
    sel_count = '0;
    for (int r = 0; r < GRID_ROWS; r++) begin
      for (int c = 0; c < GRID_COLS; c++) begin
        if (row_hit[r] && col_hit[c]) begin
          sel_alive = sel_alive | grid[r][c];
          if ((r >= 1) && (r + 1 < GRID_ROWS) && (c >= 1) && (c + 1 < GRID_COLS)) begin
            sel_count = sel_count | cnt[r][c];
          end
        end
      end
    end
  end

  // Form the result; writes report the new state, neighbors are unaffected
  always_comb begin
    cell_alive_next     = 1'b0;
    neighbor_count_next = '0;
    if (do_write) begin
      cell_alive_next     = cell_value;
      neighbor_count_next = sel_count;
    end else if (do_read) begin
      cell_alive_next     = sel_alive;
      neighbor_count_next = sel_count;
    end
  end

  // Register the result and the strobe
  always_ff @(posedge clk) begin
    if (rst) begin
      done           <= 1'b0;
      busy           <= 1'b1;
      cell_alive     <= 1'b0;
      neighbor_count <= '0;
    end else begin
      done           <= accept;
      busy           <= 1'b0;
      cell_alive     <= cell_alive_next;
      neighbor_count <= neighbor_count_next;
    end
  end

  // Every transfer gives a strobe in the next cycle
  a_done_follows: assert property (@(posedge clk) disable iff (rst)
    accept |=> done)
    else $error("transfer without result strobe");

  // No strobe without a preceding transfer
  a_no_spurious: assert property (@(posedge clk) disable iff (rst)
    !accept |=> !done)
    else $error("result strobe without transfer");

  // Step results report zero
  a_step_zero: assert property (@(posedge clk) disable iff (rst)
    (accept && (action == ACT_STEP)) |=> (!cell_alive && (neighbor_count == '0)))
    else $error("step result not zero");

  // A write inside the grid reports the written state
  a_write_echo: assert property (@(posedge clk) disable iff (rst)
    (accept && (action == ACT_WRITE) && in_grid) |=> (cell_alive == $past(cell_value)))
    else $error("write result does not match written value");

  // Counts never exceed eight neighbors
  a_count_range: assert property (@(posedge clk) disable iff (rst)
    done |-> (neighbor_count <= 4'd8))
    else $error("neighbor count out of range");

endmodule
`default_nettype wire

// ----- sim/life_cellular_automaton_grid_core_tb.sv -----
// Self-checking testbench for the life grid core: directed and random cell commands.
`default_nettype none
module life_cellular_automaton_grid_core_tb
  import lca_pkg::*;
();
  timeunit 1ns;
  timeprecision 1ps;

  localparam int GRID_ROWS = 16;
  localparam int GRID_COLS = 16;
  localparam logic [1:0] ACT_UNUSED = 2'd3;
  localparam int PHASE_ITEMS = 400;

  typedef struct {
    logic [1:0]         act;
    logic [INDEX_W-1:0] row;
    logic [INDEX_W-1:0] col;
    logic               value;
  } cell_cmd_t;

  typedef struct {
    logic               alive;
    logic [COUNT_W-1:0] count;
  } cell_report_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic start = 1'b0;
  logic [1:0] action = 2'd0;
  logic [INDEX_W-1:0] row_index = '0;
  logic [INDEX_W-1:0] col_index = '0;
  logic cell_value = 1'b0;
  logic busy;
  logic done;
  logic cell_alive;
  logic [COUNT_W-1:0] neighbor_count;

  cell_cmd_t    cmd_queue[$];
  cell_report_t report_queue[$];

  // Shadow copy of the cell array
  bit [GRID_COLS-1:0] life_grid [GRID_ROWS];

  int idle_pct = 0;
  bit hold_sender = 1'b0;
  int errors = 0;
  int n_write = 0;
  int n_step = 0;
  int n_read = 0;
  int n_unused = 0;
  int n_checked = 0;
  int peak_count = 0;

  life_cellular_automaton_grid_core #(
    .GRID_ROWS(GRID_ROWS),
    .GRID_COLS(GRID_COLS)
  ) dut (
    .clk(clk),
    .rst(rst),
    .start(start),
    .busy(busy),
    .action(action),
    .row_index(row_index),
    .col_index(col_index),
    .cell_value(cell_value),
    .done(done),
    .cell_alive(cell_alive),
    .neighbor_count(neighbor_count)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic bit on_border(int r, int c);
    return (r == 0) || (r == GRID_ROWS - 1) || (c == 0) || (c == GRID_COLS - 1);
  endfunction

  // Count the eight neighbors of an interior cell
  function automatic int live_neighbors(int r, int c);
    int n;
    n = 0;
    for (int dr = -1; dr <= 1; dr++) begin
      for (int dc = -1; dc <= 1; dc++) begin
        if (dr != 0 || dc != 0) begin
          n += life_grid[r + dr][c + dc];
        end
      end
    end
    return n;
  endfunction

  // Advance every interior cell one generation from the old grid
  function automatic void advance_generation();
    bit [GRID_COLS-1:0] old_grid [GRID_ROWS];
    int n;
    old_grid = life_grid;
    for (int r = 1; r < GRID_ROWS - 1; r++) begin
      for (int c = 1; c < GRID_COLS - 1; c++) begin
        n = 0;
        for (int dr = -1; dr <= 1; dr++) begin
          for (int dc = -1; dc <= 1; dc++) begin
            if (dr != 0 || dc != 0) begin
              n += old_grid[r + dr][c + dc];
            end
          end
        end
        if (old_grid[r][c]) begin
          life_grid[r][c] = (n >= LIVE_MIN) && (n <= LIVE_MAX);
        end else begin
          life_grid[r][c] = (n == BIRTH_COUNT);
        end
      end
    end
  endfunction

  // Apply one command to the shadow grid and return the report it should produce
  function automatic cell_report_t apply_life_cmd(cell_cmd_t cmd);
    cell_report_t rep;
    int r;
    int c;
    rep.alive = 1'b0;
    rep.count = '0;
    r = cmd.row;
    c = cmd.col;
    if (cmd.act == ACT_STEP) begin
      advance_generation();
    end else if (cmd.act == ACT_WRITE || cmd.act == ACT_READ) begin
      if (r < GRID_ROWS && c < GRID_COLS) begin
        if (cmd.act == ACT_WRITE) begin
          life_grid[r][c] = cmd.value;
        end
        rep.alive = life_grid[r][c];
        if (!on_border(r, c)) begin
          rep.count = COUNT_W'(live_neighbors(r, c));
        end
      end
    end
    return rep;
  endfunction

  function automatic void add_cmd(logic [1:0] act, int r, int c, logic v);
    cell_cmd_t cmd;
    cmd.act = act;
    cmd.row = INDEX_W'(r);
    cmd.col = INDEX_W'(c);
    cmd.value = v;
    cmd_queue.push_back(cmd);
  endfunction

  // Mostly writes and reads with steps mixed in; a few unused codes as noise
  function automatic void add_random_cmd();
    int pick;
    logic [1:0] act;
    pick = $urandom_range(99);
    if (pick < 40) begin
      act = ACT_WRITE;
    end else if (pick < 58) begin
      act = ACT_STEP;
    end else if (pick < 95) begin
      act = ACT_READ;
    end else begin
      act = ACT_UNUSED;
    end
    add_cmd(act, $urandom_range(GRID_ROWS - 1), $urandom_range(GRID_COLS - 1),
            ($urandom_range(99) < 60));
  endfunction

  // Driver: account for the transfer just made, then present the next command
  always @(posedge clk) begin
    cell_cmd_t cur;
    cell_cmd_t nxt;
    if (rst) begin
      start <= 1'b0;
    end else begin
      if (start && !busy) begin
        cur.act = action;
        cur.row = row_index;
        cur.col = col_index;
        cur.value = cell_value;
        report_queue.push_back(apply_life_cmd(cur));
        case (action)
          ACT_WRITE: n_write++;
          ACT_STEP:  n_step++;
          ACT_READ:  n_read++;
          default:   n_unused++;
        endcase
      end
      if (!(start && busy)) begin
        if (cmd_queue.size() > 0 && !hold_sender && $urandom_range(99) >= idle_pct) begin
          nxt = cmd_queue.pop_front();
          action <= nxt.act;
          row_index <= nxt.row;
          col_index <= nxt.col;
          cell_value <= nxt.value;
          start <= 1'b1;
        end else begin
          start <= 1'b0;
        end
      end
    end
  end

  // Monitor: compare each strobed result with the oldest expectation
  always @(posedge clk) begin
    cell_report_t exp_rep;
    if (!rst && done) begin
      if (report_queue.size() == 0) begin
        errors++;
        $display("%0t: unexpected result alive=%0d count=%0d", $time, cell_alive,
                 neighbor_count);
      end else begin
        exp_rep = report_queue.pop_front();
        n_checked++;
        if (cell_alive !== exp_rep.alive) begin
          errors++;
          $display("%0t: cell_alive expected %0d actual %0d", $time, exp_rep.alive,
                   cell_alive);
        end
        if (neighbor_count !== exp_rep.count) begin
          errors++;
          $display("%0t: neighbor_count expected %0d actual %0d", $time, exp_rep.count,
                   neighbor_count);
        end
        if (exp_rep.count > peak_count) begin
          peak_count = exp_rep.count;
        end
      end
    end
  end

  // Wait until nothing is pending, presented or expected
  task automatic drain();
    while (cmd_queue.size() > 0 || start || report_queue.size() > 0) begin
      @(negedge clk);
    end
  endtask

  task automatic run_phase(int pct);
    idle_pct = pct;
    for (int i = 0; i < PHASE_ITEMS; i++) begin
      add_random_cmd();
    end
  endtask

  initial begin
    int wait_cycles;
    for (int r = 0; r < GRID_ROWS; r++) begin
      life_grid[r] = '0;
    end

    // Empty grid, a fully surrounded cell, border corners, blinker, unused code
    add_cmd(ACT_READ, 0, 0, 1'b0);
    add_cmd(ACT_WRITE, 0, 0, 1'b1);
    add_cmd(ACT_WRITE, 0, 1, 1'b1);
    add_cmd(ACT_WRITE, 0, 2, 1'b1);
    add_cmd(ACT_WRITE, 1, 0, 1'b1);
    add_cmd(ACT_WRITE, 1, 2, 1'b1);
    add_cmd(ACT_WRITE, 2, 0, 1'b1);
    add_cmd(ACT_WRITE, 2, 1, 1'b1);
    add_cmd(ACT_WRITE, 2, 2, 1'b1);
    add_cmd(ACT_READ, 1, 1, 1'b0);
    add_cmd(ACT_WRITE, 1, 1, 1'b1);
    add_cmd(ACT_STEP, 0, 0, 1'b0);
    add_cmd(ACT_READ, 1, 1, 1'b1);
    add_cmd(ACT_WRITE, 15, 15, 1'b1);
    add_cmd(ACT_WRITE, 14, 14, 1'b0);
    add_cmd(ACT_UNUSED, 15, 15, 1'b1);
    add_cmd(ACT_WRITE, 7, 6, 1'b1);
    add_cmd(ACT_WRITE, 7, 7, 1'b1);
    add_cmd(ACT_WRITE, 7, 8, 1'b1);
    add_cmd(ACT_STEP, 15, 15, 1'b1);
    add_cmd(ACT_READ, 6, 7, 1'b0);
    add_cmd(ACT_READ, 8, 7, 1'b0);
    add_cmd(ACT_STEP, 0, 0, 1'b0);
    add_cmd(ACT_READ, 7, 6, 1'b0);
    add_cmd(ACT_WRITE, 0, 15, 1'b0);

    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(negedge clk);
    drain();

    // Back-to-back commands
    run_phase(0);
    drain();

    // Sender idle about half the time; pause midway until the pipe is empty
    run_phase(50);
    while (cmd_queue.size() > PHASE_ITEMS / 2) begin
      @(negedge clk);
    end
    hold_sender = 1'b1;
    while (start || report_queue.size() > 0) begin
      @(negedge clk);
    end
    repeat (4) @(negedge clk);
    hold_sender = 1'b0;
    drain();

    // Occasional gaps
    run_phase(6);
    wait_cycles = 0;
    while ((cmd_queue.size() > 0 || start || report_queue.size() > 0) && wait_cycles < 20000) begin
      @(negedge clk);
      wait_cycles++;
    end
    repeat (5) @(negedge clk);
    if (report_queue.size() > 0) begin
      errors += report_queue.size();
      $display("%0t: %0d expected results never arrived", $time, report_queue.size());
    end

    $display("Ran %0d writes, %0d steps, %0d reads, %0d unused codes; %0d results checked.",
             n_write, n_step, n_read, n_unused, n_checked);
    $display("Highest neighbor count reported: %0d; mismatches: %0d.", peak_count, errors);
    if (errors == 0) begin
      $display("** life_cellular_automaton_grid_core: PASSED **");
    end else begin
      $display("** life_cellular_automaton_grid_core: FAILED **");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #2ms;
    $display("** life_cellular_automaton_grid_core: FAILED **");
    $finish;
  end

endmodule
`default_nettype wire

// ----- filelist.f -----
rtl/lca_pkg.sv
rtl/lca_cell.sv
rtl/life_cellular_automaton_grid_core.sv
sim/life_cellular_automaton_grid_core_tb.sv
